// ===== sv/ftpt_pkg.sv =====
// ----------------------------------------------------------------------------
// ftpt_pkg
// Shared types and constants for the five-tuple policy table.
// ----------------------------------------------------------------------------
package ftpt_pkg;

  localparam int unsigned ID_W = 6;

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_LOOKUP = 2'd1;
  localparam logic [1:0] CMD_MARK   = 2'd2;

  localparam logic [6:0] PCT_MAX = 7'd100;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [7:0]  protocol;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [6:0]  percent;
    logic        status_value;
  } ftpt_req_t;

  typedef struct packed {
    logic            hit;
    logic [ID_W-1:0] entry_id;
    logic            usable;
    logic            full_error;
  } ftpt_rsp_t;

  typedef struct packed {
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [7:0]  protocol;
    logic [15:0] src_port;
    logic [15:0] dst_port;
  } ftpt_key_t;

  // Write controls from the sequencer to the entry store.
  typedef struct packed {
    logic key_we;
    logic flag_we;
    logic flag_wdata;
  } ftpt_wr_t;

  function automatic ftpt_key_t ftpt_key_of(input ftpt_req_t req);
    ftpt_key_t k;
    k.src_addr = req.src_addr;
    k.dst_addr = req.dst_addr;
    k.protocol = req.protocol;
    k.src_port = req.src_port;
    k.dst_port = req.dst_port;
    return k;
  endfunction

  // Stored port of zero matches any port.
  function automatic logic ftpt_match(input ftpt_key_t stored, input ftpt_key_t probe);
    return (stored.src_addr == probe.src_addr) &&
           (stored.dst_addr == probe.dst_addr) &&
           (stored.protocol == probe.protocol) &&
           ((stored.src_port == probe.src_port) || (stored.src_port == 16'd0)) &&
           ((stored.dst_port == probe.dst_port) || (stored.dst_port == 16'd0));
  endfunction

endpackage

// ===== sv/ftpt_store.sv =====
// ----------------------------------------------------------------------------
// ftpt_store
// Entry store: key memory and usable-flag memory, one write port each and a
// shared read address, read data registered.
// ----------------------------------------------------------------------------
module ftpt_store
  import ftpt_pkg::*;
#(
  parameter int unsigned ENTRIES = 64,
  parameter int unsigned IW      = 6
) (
  input  logic           clk_i,
  input  ftpt_wr_t       wr_i,
  input  logic [IW-1:0]  key_waddr_i,
  input  ftpt_key_t      key_wdata_i,
  input  logic [IW-1:0]  flag_waddr_i,
  input  logic [IW-1:0]  raddr_i,
  output ftpt_key_t      key_rdata_o,
  output logic           flag_rdata_o
);

  ftpt_key_t key_mem  [ENTRIES];
  logic      flag_mem [ENTRIES];

  always_ff @(posedge clk_i) begin
    if (wr_i.key_we) begin
      key_mem[key_waddr_i] <= key_wdata_i;
    end
    key_rdata_o <= key_mem[raddr_i];
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.flag_we) begin
      flag_mem[flag_waddr_i] <= wr_i.flag_wdata;
    end
    flag_rdata_o <= flag_mem[raddr_i];
  end

endmodule

// ===== sv/five_tuple_policy_table.sv =====
// ----------------------------------------------------------------------------
// five_tuple_policy_table
// Flow policy table keyed by a five-tuple, first-match lookup in insertion
// order, with insert and tail-mark commands.
// ----------------------------------------------------------------------------
// One command at a time: a command is taken when start is high and busy is
// low, and its result shows on rsp_o for exactly one cycle with done_o high;
// the receiver cannot stall it. Insert and unused codes answer in the cycle
// after the transfer. Lookup reads the entry store one entry per cycle
// through its single read port and answers on the first hit, or once the
// last stored entry has been compared. Mark walks the flags from entry 1 to
// count-1 one per cycle and answers once the walk ends. Busy drops in the
// cycle the result appears, so the next command may follow right away.
module five_tuple_policy_table
  import ftpt_pkg::*;
#(
  parameter int unsigned ENTRIES = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  input  ftpt_req_t req_i,
  output logic      busy,
  output logic      done_o,
  output ftpt_rsp_t rsp_o
);

  localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CW = $clog2(ENTRIES + 1);
  localparam int unsigned AW = CW + 7;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOK,
    ST_MARK
  } state_e;

  state_e           state_q;
  logic [CW-1:0]    count_q;
  logic [CW-1:0]    rd_idx_q;
  logic [IW-1:0]    cmp_idx_q;
  logic             vld_q;
  logic [CW-1:0]    mk_idx_q;
  logic [AW-1:0]    acc_q;
  logic [AW-1:0]    thr_q;
  ftpt_req_t        req_q;
  logic             done_q;
  ftpt_rsp_t        rsp_q;

  logic             accept;
  logic             full;
  logic             ins_we;
  logic             issuing;
  logic             hit_now;
  logic             mark_wr;
  logic [6:0]       pct_c;
  logic [AW-1:0]    thr_d;
  ftpt_wr_t         wr;
  logic [IW-1:0]    flag_waddr;
  ftpt_key_t        key_rd;
  logic             flag_rd;
  logic             done_d;
  ftpt_rsp_t        rsp_d;

  always_comb begin
    accept  = start && (state_q == ST_IDLE);
    full    = (count_q == CW'(ENTRIES));
    ins_we  = accept && (req_i.cmd == CMD_INSERT) && !full;
    issuing = (state_q == ST_LOOK) && (rd_idx_q < count_q);
    hit_now = (state_q == ST_LOOK) && vld_q && ftpt_match(key_rd, ftpt_key_of(req_q));
    // Entry i is marked when 100*i exceeds count*(100-percent).
    mark_wr = (state_q == ST_MARK) && (mk_idx_q < count_q) && (acc_q > thr_q);
    pct_c   = (req_i.percent > PCT_MAX) ? PCT_MAX : req_i.percent;
    thr_d   = AW'(count_q) * AW'(PCT_MAX - pct_c);

    wr.key_we     = ins_we;
    wr.flag_we    = ins_we || mark_wr;
    wr.flag_wdata = ins_we ? 1'b1 : req_q.status_value;
    flag_waddr    = (state_q == ST_MARK) ? mk_idx_q[IW-1:0] : count_q[IW-1:0];
  end

  always_comb begin
    done_d = 1'b0;
    rsp_d  = rsp_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (req_i.cmd)
            CMD_INSERT: begin
              done_d = 1'b1;
              rsp_d  = '0;
              if (full) begin
                rsp_d.full_error = 1'b1;
              end else begin
                rsp_d.hit      = 1'b1;
                rsp_d.entry_id = ID_W'(count_q[IW-1:0]);
                rsp_d.usable   = 1'b1;
              end
            end
            CMD_LOOKUP, CMD_MARK: begin
            end
            default: begin
              done_d = 1'b1;
              rsp_d  = '0;
            end
          endcase
        end
      end
      ST_LOOK: begin
        if (hit_now) begin
          done_d         = 1'b1;
          rsp_d          = '0;
          rsp_d.hit      = 1'b1;
          rsp_d.entry_id = ID_W'(cmp_idx_q);
          rsp_d.usable   = flag_rd;
        end else if (!issuing) begin
          // every stored entry compared without a match
          done_d = 1'b1;
          rsp_d  = '0;
        end
      end
      ST_MARK: begin
        if (!(mk_idx_q < count_q)) begin
          done_d = 1'b1;
          rsp_d  = '0;
        end
      end
      default: begin
      end
    endcase
  end

  ftpt_store #(
    .ENTRIES (ENTRIES),
    .IW      (IW)
  ) u_store (
    .clk_i        (clk_i),
    .wr_i         (wr),
    .key_waddr_i  (count_q[IW-1:0]),
    .key_wdata_i  (ftpt_key_of(req_i)),
    .flag_waddr_i (flag_waddr),
    .raddr_i      (rd_idx_q[IW-1:0]),
    .key_rdata_o  (key_rd),
    .flag_rdata_o (flag_rd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      count_q   <= '0;
      rd_idx_q  <= '0;
      cmp_idx_q <= '0;
      vld_q     <= 1'b0;
      mk_idx_q  <= '0;
      acc_q     <= '0;
      thr_q     <= '0;
      req_q     <= '0;
      done_q    <= 1'b0;
      rsp_q     <= '0;
    end else begin
      done_q <= done_d;
      rsp_q  <= rsp_d;
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            req_q <= req_i;
            case (req_i.cmd)
              CMD_INSERT: begin
                if (!full) begin
                  count_q <= count_q + 1'b1;
                end
              end
              CMD_LOOKUP: begin
                state_q  <= ST_LOOK;
                rd_idx_q <= '0;
                vld_q    <= 1'b0;
              end
              CMD_MARK: begin
                state_q  <= ST_MARK;
                mk_idx_q <= CW'(1);
                acc_q    <= AW'(PCT_MAX);
                thr_q    <= thr_d;
              end
              default: begin
              end
            endcase
          end
        end
        ST_LOOK: begin
          vld_q     <= issuing;
          cmp_idx_q <= rd_idx_q[IW-1:0];
          if (issuing) begin
            rd_idx_q <= rd_idx_q + 1'b1;
          end
          if (hit_now || !issuing) begin
            state_q <= ST_IDLE;
          end
        end
        ST_MARK: begin
          if (mk_idx_q < count_q) begin
            mk_idx_q <= mk_idx_q + 1'b1;
            acc_q    <= acc_q + AW'(PCT_MAX);
          end else begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign busy   = (state_q != ST_IDLE);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(ENTRIES))
    else $error("entry count beyond table size");

  a_insert_answers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (req_i.cmd == CMD_INSERT)) |=> done_q)
    else $error("insert did not answer in the next cycle");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (state_q == ST_IDLE))
    else $error("result shown while still busy");

  a_full_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && rsp_q.full_error) |-> (!rsp_q.hit && !rsp_q.usable))
    else $error("full error together with hit");

  a_usable_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && rsp_q.usable) |-> rsp_q.hit)
    else $error("usable flag without a hit");

  a_mark_no_keys: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MARK) |-> (!wr.key_we && (mk_idx_q != '0)))
    else $error("mark touched keys or entry zero");

endmodule

// ===== bench/ftpt_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ftpt_checker
// Watches the command and result channels of the five-tuple policy table,
// keeps its own copy of the stored flows and usable flags, predicts the
// answer to every command taken and compares each result field by field.
// ----------------------------------------------------------------------------
module ftpt_checker
  import ftpt_pkg::*;
#(
  parameter int unsigned ENTRIES = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  input  logic      busy,
  input  ftpt_req_t req_i,
  input  logic      done_o,
  input  ftpt_rsp_t rsp_o,
  output int        errors_o,
  output int        pending_o,
  output int        compared_o
);

  localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  ftpt_key_t   flow_keys   [ENTRIES];
  logic        flow_usable [ENTRIES];
  int unsigned flow_count;
  ftpt_rsp_t   answer_q [$];

  function automatic logic port_ok(input logic [15:0] stored, input logic [15:0] probe);
    return (stored == 16'd0) || (stored == probe);
  endfunction

  // Update the shadow table for one command and return its answer.
  function automatic ftpt_rsp_t apply_command(input ftpt_req_t r);
    ftpt_rsp_t   a;
    int unsigned pct;
    int unsigned first;
    a = '0;
    case (r.cmd)
      CMD_INSERT: begin
        if (flow_count >= ENTRIES) begin
          a.full_error = 1'b1;
        end else begin
          flow_keys[flow_count[IW-1:0]].src_addr = r.src_addr;
          flow_keys[flow_count[IW-1:0]].dst_addr = r.dst_addr;
          flow_keys[flow_count[IW-1:0]].protocol = r.protocol;
          flow_keys[flow_count[IW-1:0]].src_port = r.src_port;
          flow_keys[flow_count[IW-1:0]].dst_port = r.dst_port;
          flow_usable[flow_count[IW-1:0]] = 1'b1;
          a.hit      = 1'b1;
          a.entry_id = flow_count[ID_W-1:0];
          a.usable   = 1'b1;
          flow_count++;
        end
      end
      CMD_LOOKUP: begin
        for (int unsigned i = 0; i < flow_count; i++) begin
          if (flow_keys[i[IW-1:0]].src_addr == r.src_addr &&
              flow_keys[i[IW-1:0]].dst_addr == r.dst_addr &&
              flow_keys[i[IW-1:0]].protocol == r.protocol &&
              port_ok(flow_keys[i[IW-1:0]].src_port, r.src_port) &&
              port_ok(flow_keys[i[IW-1:0]].dst_port, r.dst_port)) begin
            a.hit      = 1'b1;
            a.entry_id = i[ID_W-1:0];
            a.usable   = flow_usable[i[IW-1:0]];
            break;
          end
        end
      end
      CMD_MARK: begin
        // clamp the share, entry 0 is never touched
        pct   = 32'((r.percent > PCT_MAX) ? PCT_MAX : r.percent);
        first = flow_count * (32'(PCT_MAX) - pct) / 32'(PCT_MAX) + 1;
        for (int unsigned i = first; i < flow_count; i++) begin
          flow_usable[i[IW-1:0]] = r.status_value;
        end
      end
      default: begin
      end
    endcase
    return a;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    ftpt_rsp_t want;
    if (!rst_ni) begin
      flow_count = 0;
      answer_q.delete();
      pending_o  = 0;
      errors_o   = 0;
      compared_o = 0;
    end else begin
      if (done_o) begin
        compared_o++;
        if (answer_q.size() == 0) begin
          errors_o++;
          $error("result transfer with no command outstanding: %h", rsp_o);
        end else begin
          want = answer_q.pop_front();
          if (rsp_o.hit !== want.hit) begin
            errors_o++;
            $error("hit: expected %0b, actual %0b", want.hit, rsp_o.hit);
          end
          if (rsp_o.entry_id !== want.entry_id) begin
            errors_o++;
            $error("entry_id: expected %0d, actual %0d", want.entry_id, rsp_o.entry_id);
          end
          if (rsp_o.usable !== want.usable) begin
            errors_o++;
            $error("usable: expected %0b, actual %0b", want.usable, rsp_o.usable);
          end
          if (rsp_o.full_error !== want.full_error) begin
            errors_o++;
            $error("full_error: expected %0b, actual %0b", want.full_error,
                   rsp_o.full_error);
          end
        end
      end
      if (start && !busy) begin
        answer_q.insert(answer_q.size(), apply_command(req_i));
      end
      pending_o = answer_q.size();
    end
  end

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Drives directed and random insert, lookup, mark and unused-code commands
// into the five-tuple policy table with random gaps; the checker predicts and
// compares every result, and this module reports the verdict.
// ----------------------------------------------------------------------------
module tb;
  import ftpt_pkg::*;

  localparam logic [1:0]  CMD_UNUSED   = 2'd3;
  localparam int unsigned ENTRIES      = 64;
  localparam int          RANDOM_ITEMS = 1925;
  localparam int          STALL_LIMIT  = 2000;
  localparam int          SETTLE       = 80;

  logic      clk_i;
  logic      rst_ni;
  logic      start;
  logic      busy;
  logic      done_o;
  ftpt_req_t req_i;
  ftpt_rsp_t rsp_o;

  int errors;
  int pending;
  int compared;
  int stall_cycles;
  int n_insert, n_lookup, n_mark, n_other;
  bit quiet;

  ftpt_key_t held_keys [$];  // keys the table holds, in insertion order

  five_tuple_policy_table #(.ENTRIES(ENTRIES)) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .req_i  (req_i),
    .busy   (busy),
    .done_o (done_o),
    .rsp_o  (rsp_o)
  );

  ftpt_checker #(.ENTRIES(ENTRIES)) u_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .req_i      (req_i),
    .done_o     (done_o),
    .rsp_o      (rsp_o),
    .errors_o   (errors),
    .pending_o  (pending),
    .compared_o (compared)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      stall_cycles = 0;
    end else begin
      if ((start && !busy) || done_o) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
          $display("Watchdog: no transfer for %0d cycles", STALL_LIMIT);
          $display("Some tests failed");
          $finish;
        end
      end
    end
  end

  function automatic logic [31:0] pick_addr();
    case ($urandom_range(0, 5))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'h0A00_0001;
      3:       return 32'hC0A8_0101;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [15:0] pick_port();
    case ($urandom_range(0, 5))
      0, 1:    return 16'd0;
      2:       return 16'hFFFF;
      3:       return 16'd443;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic logic [7:0] pick_proto();
    case ($urandom_range(0, 3))
      0:       return 8'd6;
      1:       return 8'd17;
      2:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic ftpt_key_t fresh_key();
    ftpt_key_t k;
    k.src_addr = pick_addr();
    k.dst_addr = pick_addr();
    k.protocol = pick_proto();
    k.src_port = pick_port();
    k.dst_port = pick_port();
    return k;
  endfunction

  // Mostly reuse a stored key so lookups hit, with ports bent to test wildcards.
  function automatic ftpt_key_t probe_key();
    ftpt_key_t k;
    if (held_keys.size() == 0 || $urandom_range(0, 3) == 0) begin
      return fresh_key();
    end
    k = held_keys[$urandom_range(0, held_keys.size() - 1)];
    case ($urandom_range(0, 4))
      2: begin
        if (k.src_port == 16'd0) k.src_port = 16'($urandom_range(0, 65535));
        if (k.dst_port == 16'd0) k.dst_port = 16'($urandom_range(0, 65535));
      end
      3:       k.src_port = 16'($urandom_range(0, 65535));
      4:       k.dst_port = 16'($urandom_range(0, 65535));
      default: begin
      end
    endcase
    return k;
  endfunction

  function automatic ftpt_req_t noise_req();
    ftpt_req_t r;
    r.cmd          = 2'($urandom_range(0, 3));
    r.src_addr     = $urandom();
    r.dst_addr     = $urandom();
    r.protocol     = 8'($urandom_range(0, 255));
    r.src_port     = 16'($urandom_range(0, 65535));
    r.dst_port     = 16'($urandom_range(0, 65535));
    r.percent      = 7'($urandom_range(0, 127));
    r.status_value = 1'($urandom_range(0, 1));
    return r;
  endfunction

  function automatic ftpt_req_t make_req(input logic [1:0] cmd, input ftpt_key_t k,
                                         input logic [6:0] pct, input logic val);
    ftpt_req_t r;
    r.cmd          = cmd;
    r.src_addr     = k.src_addr;
    r.dst_addr     = k.dst_addr;
    r.protocol     = k.protocol;
    r.src_port     = k.src_port;
    r.dst_port     = k.dst_port;
    r.percent      = pct;
    r.status_value = val;
    return r;
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Called at a falling edge; returns at the falling edge after the transfer, or after the random gap that follows it.
  task automatic send(input ftpt_req_t r);
    int n;
    req_i <= r;
    start <= 1'b1;
    do @(posedge clk_i); while (busy);
    @(negedge clk_i);
    case (r.cmd)
      CMD_INSERT: begin
        n_insert++;
        if (held_keys.size() < ENTRIES) begin
          held_keys.insert(held_keys.size(),
                           ftpt_key_t'({r.src_addr, r.dst_addr, r.protocol,
                                        r.src_port, r.dst_port}));
        end
      end
      CMD_LOOKUP: n_lookup++;
      CMD_MARK:   n_mark++;
      default:    n_other++;
    endcase
    n = quiet ? 0 : gap_len();
    if (n > 0) begin
      start <= 1'b0;
      req_i <= noise_req();
      repeat (n) @(negedge clk_i);
    end
  endtask

  // Hold off the sender until every outstanding answer has come back.
  task automatic drain();
    start <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
  endtask

  initial begin
    ftpt_key_t k0, k1, ka, ka2, kb;
    ftpt_key_t k;
    ftpt_req_t r;
    int        pick;

    rst_ni       = 1'b0;
    start        = 1'b0;
    req_i        = '0;
    quiet        = 1'b0;
    n_insert = 0; n_lookup = 0; n_mark = 0; n_other = 0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    k0  = ftpt_key_t'({32'h0000_0000, 32'h0000_0000, 8'h00, 16'h0000, 16'h0000});
    k1  = ftpt_key_t'({32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 16'hFFFF, 16'hFFFF});
    ka  = ftpt_key_t'({32'h0A00_0001, 32'h0A00_0002, 8'd6, 16'd0, 16'd443});
    ka2 = ftpt_key_t'({32'h0A00_0001, 32'h0A00_0002, 8'd6, 16'd1234, 16'd443});
    kb  = ftpt_key_t'({32'hC0A8_0101, 32'h0808_0808, 8'd17, 16'd53, 16'd0});

    // empty table: miss, harmless mark, unused code
    send(make_req(CMD_LOOKUP, k1, 7'd0, 1'b0));
    send(make_req(CMD_MARK, k0, PCT_MAX, 1'b0));
    send(make_req(CMD_UNUSED, k1, 7'h7F, 1'b1));
    send(make_req(CMD_INSERT, k0, 7'd0, 1'b0));
    send(make_req(CMD_INSERT, k1, 7'h7F, 1'b1));
    send(make_req(CMD_INSERT, ka, 7'd0, 1'b0));
    send(make_req(CMD_INSERT, ka2, 7'd0, 1'b0));
    send(make_req(CMD_INSERT, kb, 7'd0, 1'b0));
    // wildcard ports on both sides
    k = k0; k.src_port = 16'hFFFF; k.dst_port = 16'hFFFF;
    send(make_req(CMD_LOOKUP, k, 7'd0, 1'b0));
    send(make_req(CMD_LOOKUP, k1, 7'd0, 1'b0));
    // first match wins over the later exact entry
    send(make_req(CMD_LOOKUP, ka2, 7'd0, 1'b0));
    k = ka2; k.dst_port = 16'd80;
    send(make_req(CMD_LOOKUP, k, 7'd0, 1'b0));
    k = kb; k.dst_port = 16'd9999;
    send(make_req(CMD_LOOKUP, k, 7'd0, 1'b0));
    k = kb; k.src_port = 16'd54;
    send(make_req(CMD_LOOKUP, k, 7'd0, 1'b0));
    send(make_req(CMD_MARK, k0, 7'd0, 1'b0));
    send(make_req(CMD_MARK, k0, PCT_MAX, 1'b0));
    send(make_req(CMD_LOOKUP, k0, 7'd0, 1'b0));
    send(make_req(CMD_LOOKUP, k1, 7'd0, 1'b0));
    // share above the maximum acts as the maximum
    send(make_req(CMD_MARK, k0, 7'h7F, 1'b1));
    send(make_req(CMD_LOOKUP, kb, 7'd0, 1'b0));
    send(make_req(CMD_MARK, k0, 7'd50, 1'b0));
    send(make_req(CMD_LOOKUP, ka2, 7'd0, 1'b0));
    send(make_req(CMD_LOOKUP, kb, 7'd0, 1'b0));
    send(make_req(CMD_UNUSED, k0, 7'd0, 1'b0));
    drain();

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 150 == 0) quiet = ($urandom_range(0, 3) == 0);
      if (i % 400 == 399) drain();
      r    = noise_req();
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        k = ($urandom_range(0, 2) == 0) ? probe_key() : fresh_key();
        r = make_req(CMD_INSERT, k, r.percent, r.status_value);
      end else if (pick < 72) begin
        r = make_req(CMD_LOOKUP, probe_key(), r.percent, r.status_value);
      end else if (pick < 95) begin
        r.cmd = CMD_MARK;
      end else begin
        r.cmd = CMD_UNUSED;
      end
      send(r);
    end

    drain();
    repeat (SETTLE) @(negedge clk_i);
    $display("Drove %0d commands: %0d inserts, %0d lookups, %0d marks, %0d unused code",
             n_insert + n_lookup + n_mark + n_other, n_insert, n_lookup, n_mark, n_other);
    $display("Compared %0d results; table filled to %0d of %0d entries",
             compared, held_keys.size(), ENTRIES);
    if (errors == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
